/* rtl/core/mhpq_pkg.sv */
// shared types and constants of the min-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

	// width of an entry identifier
	localparam int ID_W = 11;

	// request operation codes
	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_DECREASE   = 2'd1,
		OP_DELETE_MIN = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_SRCH,
		S_DEL_ROOT,
		S_DEL_LAST,
		S_DEL_TAKE,
		S_DN_RD,
		S_DN_L,
		S_DN_R,
		S_FIN
	} state_t;

endpackage

/* rtl/core/mhpq_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/min_heap_priority_queue_core.sv */
// binary min-heap priority queue with insert, decrease-key and delete-min
// insert climbs from the new last slot a level at a time; full insert, empty delete and spare code
//   go straight to the result; decrease scans the ids linearly from slot 1, finishes when the
//   found key does not drop, climbs from that slot when it does, and scans all slots when absent
// delete-min reads the root and the last entry, then, unless it was the only one, sifts it down
// throughput: one request at a time, the next accepted in the cycle after the result loads;
//   a decrease is bounded by the linear id scan
// reset: the fill count goes to zero at once; heap ram contents are not cleared
`timescale 1ns / 1ps

module min_heap_priority_queue_core #(
	parameter int CAPACITY = 2048,
	parameter int KEY_BITS = 21
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            operation,
	input  logic [mhpq_pkg::ID_W-1:0]             item_id,
	input  logic [KEY_BITS-1:0]                   key,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mhpq_pkg::ID_W-1:0]             out_id,
	output logic [KEY_BITS-1:0]                   out_key,
	output mhpq_pkg::status_t                     status,
	output logic [$clog2(CAPACITY+1)-1:0]         occupancy
);

	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = ID_W + KEY_BITS;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	state_t state_q, state_d;

	// control registers
	logic [CW-1:0]   cnt_q;
	logic            chk_s1;
	logic            out_valid_q;

	// payload registers
	logic [ID_W-1:0]     id_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CW-1:0]       pos_q;
	logic [CW:0]         scan_q;
	logic [CW-1:0]       chkpos_s1;
	logic [DW-1:0]       last_q;
	logic [DW-1:0]       left_q;
	status_t             st_q;
	logic [ID_W-1:0]     res_id_q;
	logic [KEY_BITS-1:0] res_key_q;
	logic [ID_W-1:0]     out_id_q;
	logic [KEY_BITS-1:0] out_key_q;
	status_t             out_st_q;
	logic [CW-1:0]       out_occ_q;

	// heap ram port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	mhpq_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_heap_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// decode of read data and heap navigation
	logic [KEY_BITS-1:0] rd_key;
	logic [ID_W-1:0]     rd_id;
	logic [KEY_BITS-1:0] last_key;
	logic [KEY_BITS-1:0] left_key;
	logic [CW-1:0]       par_pos;
	logic [CW:0]         child_l;
	logic [CW:0]         child_r;
	logic                l_ok;
	logic                r_ok;
	logic                up_move;
	logic                sel_right;
	logic [DW-1:0]       sel_data;
	logic [CW-1:0]       sel_pos;
	logic                dn_move;
	logic                match;
	logic                scan_more;
	logic                accept;
	logic                out_load;
	logic [DW-1:0]       new_entry;

	assign rd_key    = ram_rdata[KEY_BITS-1:0];
	assign rd_id     = ram_rdata[DW-1:KEY_BITS];
	assign last_key  = last_q[KEY_BITS-1:0];
	assign left_key  = left_q[KEY_BITS-1:0];
	assign par_pos   = pos_q >> 1;
	assign child_l   = {pos_q, 1'b0};
	assign child_r   = child_l + (CW+1)'(1);
	assign l_ok      = child_l <= {1'b0, cnt_q};
	assign r_ok      = child_r <= {1'b0, cnt_q};
	assign up_move   = key_q < rd_key;
	assign new_entry = {id_q, key_q};
	assign match     = chk_s1 && (rd_id == id_q);
	assign scan_more = scan_q <= {1'b0, cnt_q};
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// child choice: right only when strictly smaller than the held left child
	always_comb begin
		sel_right = 1'b0;
		sel_data  = ram_rdata;
		sel_pos   = child_l[CW-1:0];
		if (state_q == S_DN_R) begin
			sel_right = rd_key < left_key;
			sel_data  = sel_right ? ram_rdata : left_q;
			sel_pos   = sel_right ? child_r[CW-1:0] : child_l[CW-1:0];
		end
	end
	assign dn_move = last_key > sel_data[KEY_BITS-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_INSERT:     state_d = (cnt_q >= CAP_C) ? S_FIN : S_UP_RD;
						OP_DECREASE:   state_d = (cnt_q == '0) ? S_FIN : S_SRCH;
						OP_DELETE_MIN: state_d = (cnt_q == '0) ? S_FIN : S_DEL_ROOT;
						default:       state_d = S_FIN;
					endcase
				end
			end
			S_UP_RD:    state_d = (pos_q == ONE_C) ? S_FIN : S_UP_CMP;
			S_UP_CMP: begin
				if (!up_move) begin
					state_d = S_FIN;
				end else if (par_pos == ONE_C) begin
					state_d = S_UP_RD;
				end
			end
			S_SRCH: begin
				if (match) begin
					state_d = up_move ? S_UP_RD : S_FIN;
				end else if (chk_s1 && chkpos_s1 == cnt_q) begin
					state_d = S_FIN;
				end
			end
			S_DEL_ROOT: state_d = S_DEL_LAST;
			S_DEL_LAST: state_d = S_DEL_TAKE;
			S_DEL_TAKE: state_d = (cnt_q == ONE_C) ? S_FIN : S_DN_RD;
			S_DN_RD:    state_d = l_ok ? S_DN_L : S_FIN;
			S_DN_L: begin
				if (r_ok) begin
					state_d = S_DN_R;
				end else begin
					state_d = dn_move ? S_DN_RD : S_FIN;
				end
			end
			S_DN_R:     state_d = dn_move ? S_DN_RD : S_FIN;
			S_FIN:      state_d = (!out_valid_q || out_ready) ? S_IDLE : S_FIN;
			default:    state_d = S_IDLE;
		endcase
	end

	// ram accesses per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(pos_q - ONE_C);
		ram_wdata = new_entry;
		ram_re    = 1'b0;
		ram_raddr = AW'(par_pos - ONE_C);
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_UP_RD: begin
				if (pos_q == ONE_C) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (up_move) begin
					// parent moves down, fetch the next parent
					ram_wdata = ram_rdata;
					ram_re    = par_pos != ONE_C;
					ram_raddr = AW'((par_pos >> 1) - ONE_C);
				end
			end
			S_SRCH: begin
				ram_re    = scan_more;
				ram_raddr = AW'(scan_q - (CW+1)'(1));
			end
			S_DEL_ROOT: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			S_DEL_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(cnt_q - ONE_C);
			end
			S_DN_RD: begin
				if (l_ok) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(child_l - (CW+1)'(1));
				end else begin
					ram_we    = 1'b1;
					ram_wdata = last_q;
				end
			end
			S_DN_L: begin
				if (r_ok) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(child_r - (CW+1)'(1));
				end else begin
					ram_we    = 1'b1;
					ram_wdata = dn_move ? sel_data : last_q;
				end
			end
			S_DN_R: begin
				ram_we    = 1'b1;
				ram_wdata = dn_move ? sel_data : last_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// fill count
			if (accept && operation == OP_INSERT && cnt_q < CAP_C) begin
				cnt_q <= cnt_q + ONE_C;
			end else if (state_q == S_DEL_TAKE) begin
				cnt_q <= cnt_q - ONE_C;
			end
			// scan read in flight
			if (state_q == S_SRCH) begin
				chk_s1 <= scan_more;
			end else begin
				chk_s1 <= 1'b0;
			end
			// result register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					id_q      <= item_id;
					key_q     <= key;
					res_id_q  <= '0;
					res_key_q <= '0;
					st_q      <= ST_OK;
					pos_q     <= cnt_q + ONE_C;
					scan_q    <= (CW+1)'(1);
					case (operation)
						OP_INSERT:     if (cnt_q >= CAP_C) st_q <= ST_FULL;
						OP_DECREASE:   if (cnt_q == '0) st_q <= ST_NOT_FOUND;
						OP_DELETE_MIN: if (cnt_q == '0) st_q <= ST_EMPTY;
						default:       ;
					endcase
				end
			end
			S_UP_CMP: begin
				if (up_move) begin
					pos_q <= par_pos;
				end
			end
			S_SRCH: begin
				if (scan_more) begin
					scan_q    <= scan_q + (CW+1)'(1);
					chkpos_s1 <= scan_q[CW-1:0];
				end
				if (match) begin
					pos_q <= chkpos_s1;
				end else if (chk_s1 && chkpos_s1 == cnt_q) begin
					st_q <= ST_NOT_FOUND;
				end
			end
			S_DEL_LAST: begin
				res_id_q  <= rd_id;
				res_key_q <= rd_key;
			end
			S_DEL_TAKE: begin
				last_q <= ram_rdata;
				pos_q  <= ONE_C;
			end
			S_DN_L: begin
				left_q <= ram_rdata;
				if (!r_ok && dn_move) begin
					pos_q <= sel_pos;
				end
			end
			S_DN_R: begin
				if (dn_move) begin
					pos_q <= sel_pos;
				end
			end
			S_FIN: begin
				if (out_load) begin
					out_id_q  <= res_id_q;
					out_key_q <= res_key_q;
					out_st_q  <= st_q;
					out_occ_q <= cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_id    = out_id_q;
	assign out_key   = out_key_q;
	assign status    = out_st_q;
	assign occupancy = out_occ_q;

endmodule

/* test/min_heap_priority_queue_core_test.sv */
// testbench of the min-heap priority queue core: directed, random, back-pressure and fill tests
`timescale 1ns / 1ps

module min_heap_priority_queue_core_test;
	import mhpq_pkg::*;

	localparam int CAP = 2048;
	localparam int KEY_W = 21;
	localparam int OCC_W = $clog2(CAP + 1);
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	// operation code the block leaves unused
	localparam logic [1:0] OP_SPARE = 2'd3;

	// one reply of the queue
	typedef struct {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
		status_t          st;
		logic [OCC_W-1:0] occ;
	} heap_reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           operation;
	logic [ID_W-1:0]      item_id;
	logic [KEY_W-1:0]     key;
	logic                 out_valid;
	logic                 out_ready;
	logic [ID_W-1:0]      out_id;
	logic [KEY_W-1:0]     out_key;
	status_t              status;
	logic [OCC_W-1:0]     occupancy;

	// mirror of the heap array, root at slot 1
	logic [ID_W-1:0]  heap_id [1:CAP];
	logic [KEY_W-1:0] heap_key [1:CAP];
	int               heap_fill;

	heap_reply_t heap_replies[$];
	int          error_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          stall_hold;

	min_heap_priority_queue_core #(
		.CAPACITY(CAP),
		.KEY_BITS(KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.item_id(item_id),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_id(out_id),
		.out_key(out_key),
		.status(status),
		.occupancy(occupancy)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#(64'd24_000_000);
		$display("FAIL");
		$finish;
	end

	// move an entry toward the root while strictly smaller than its parent
	function automatic void heap_raise(input int pos, input logic [ID_W-1:0] id,
			input logic [KEY_W-1:0] k);
		while (pos > 1 && k < heap_key[pos / 2]) begin
			heap_id[pos] = heap_id[pos / 2];
			heap_key[pos] = heap_key[pos / 2];
			pos = pos / 2;
		end
		heap_id[pos] = id;
		heap_key[pos] = k;
	endfunction

	// apply one request to the mirror and return the reply it should produce
	function automatic heap_reply_t heap_apply_op(input logic [1:0] op,
			input logic [ID_W-1:0] id, input logic [KEY_W-1:0] k);
		heap_reply_t      r;
		int               pos;
		int               i;
		int               child;
		int               n;
		logic [ID_W-1:0]  last_id;
		logic [KEY_W-1:0] last_key;
		r.id = '0;
		r.key = '0;
		r.st = ST_OK;
		if (op == OP_INSERT) begin
			if (heap_fill >= CAP) begin
				r.st = ST_FULL;
			end else begin
				heap_fill++;
				heap_raise(heap_fill, id, k);
			end
		end else if (op == OP_DECREASE) begin
			pos = 0;
			for (i = 1; i <= heap_fill; i++) begin
				if (heap_id[i] == id) begin
					pos = i;
					break;
				end
			end
			if (pos == 0)
				r.st = ST_NOT_FOUND;
			else if (k < heap_key[pos])
				heap_raise(pos, id, k);
		end else if (op == OP_DELETE_MIN) begin
			if (heap_fill == 0) begin
				r.st = ST_EMPTY;
			end else begin
				n = heap_fill - 1;
				last_id = heap_id[heap_fill];
				last_key = heap_key[heap_fill];
				r.id = heap_id[1];
				r.key = heap_key[1];
				i = 1;
				while (2 * i <= n) begin
					child = 2 * i;
					if (child + 1 <= n && heap_key[child + 1] < heap_key[child])
						child++;
					if (last_key > heap_key[child]) begin
						heap_id[i] = heap_id[child];
						heap_key[i] = heap_key[child];
						i = child;
					end else begin
						break;
					end
				end
				if (n > 0) begin
					heap_id[i] = last_id;
					heap_key[i] = last_key;
				end
				heap_fill = n;
			end
		end
		r.occ = heap_fill[OCC_W-1:0];
		return r;
	endfunction

	task automatic report_error(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// send one request, honoring the sender idle rate
	task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] id,
			input logic [KEY_W-1:0] k);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		item_id <= id;
		key <= k;
		do @(posedge clk); while (!in_ready);
		heap_replies.push_back(heap_apply_op(op, id, k));
	endtask

	// wait until every reply is in, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (heap_replies.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	// result side: random stalls, long hold-off on demand, compare with oldest reply
	initial begin : result_checker
		heap_reply_t want;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (heap_replies.size() == 0) begin
					report_error($sformatf("result with no request pending, id %0d key %0d",
						out_id, out_key));
				end else begin
					want = heap_replies.pop_front();
					if (out_id !== want.id)
						report_error($sformatf("out_id %0d, want %0d", out_id, want.id));
					if (out_key !== want.key)
						report_error($sformatf("out_key %0d, want %0d", out_key, want.key));
					if (status !== want.st)
						report_error($sformatf("status %0d, want %0d", status, want.st));
					if (occupancy !== want.occ)
						report_error($sformatf("occupancy %0d, want %0d", occupancy, want.occ));
				end
			end
			if (stall_hold > 0) begin
				out_ready <= 1'b0;
				stall_hold <= stall_hold - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// field extremes, every operation and the corner cases
	task automatic test_directed();
		send_request(OP_DELETE_MIN, 11'd0, '0);
		send_request(OP_DECREASE, 11'd3, 21'd7);
		send_request(OP_SPARE, 11'd0, '0);
		send_request(OP_INSERT, 11'd0, KEY_MAX);
		send_request(OP_INSERT, 11'd2047, 21'd0);
		send_request(OP_INSERT, 11'h555, 21'h0AAAAA);
		send_request(OP_INSERT, 11'h2AA, 21'h155555);
		send_request(OP_INSERT, 11'd5, 21'd100);
		// same id again, lands closer to the root
		send_request(OP_INSERT, 11'd5, 21'd50);
		// equal key does not pass its parent
		send_request(OP_INSERT, 11'd6, 21'd50);
		send_request(OP_DECREASE, 11'd5, 21'd40);
		// new key equal or higher leaves the entry alone
		send_request(OP_DECREASE, 11'd6, 21'd50);
		send_request(OP_DECREASE, 11'd6, 21'd60);
		send_request(OP_DECREASE, 11'd9, 21'd0);
		send_request(OP_DECREASE, 11'd0, 21'd0);
		send_request(OP_SPARE, 11'd2047, KEY_MAX);
		repeat (8) send_request(OP_DELETE_MIN, 11'd0, '0);
		wait_drained();
	endtask

	// random mix kept at modest depth, small id pool for hits and duplicates
	task automatic test_random_mix(input int count);
		int               r;
		int               ins_pct;
		int               slot;
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] k;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			ins_pct = heap_fill < 6 ? 55 : (heap_fill > 48 ? 20 : 40);
			id = $urandom_range(1) ? 11'($urandom_range(31)) : 11'($urandom_range(2047));
			case ($urandom_range(2))
				0: k = 21'($urandom_range(15));
				1: k = 21'($urandom_range(4095));
				default: k = 21'($urandom_range(2097151));
			endcase
			if (r < 2) begin
				send_request(OP_SPARE, id, k);
			end else if (r < 2 + ins_pct) begin
				send_request(OP_INSERT, id, k);
			end else if (r < 32 + ins_pct) begin
				// mostly target a held entry with a lower key
				if (heap_fill > 0 && $urandom_range(99) < 75) begin
					slot = $urandom_range(heap_fill, 1);
					id = heap_id[slot];
					if (heap_key[slot] != 0 && $urandom_range(99) < 80)
						k = 21'($urandom_range(heap_key[slot] - 1));
				end
				send_request(OP_DECREASE, id, k);
			end else begin
				send_request(OP_DELETE_MIN, id, k);
			end
		end
		wait_drained();
	endtask

	// result side held off while requests keep coming
	task automatic test_backpressure();
		stall_hold <= 400;
		for (int n = 0; n < 40; n++)
			send_request($urandom_range(2) == 0 ? OP_DELETE_MIN : OP_INSERT,
				11'($urandom_range(2047)), 21'($urandom_range(2097151)));
		wait_drained();
	endtask

	// fill to capacity, hit full and long scans, then drain past empty
	task automatic test_fill_and_drain();
		while (heap_fill < CAP)
			send_request(OP_INSERT, 11'($urandom_range(2046)), 21'($urandom_range(2097151)));
		send_request(OP_INSERT, 11'd2047, 21'd0);
		send_request(OP_INSERT, 11'd1, KEY_MAX);
		send_request(OP_DECREASE, heap_id[CAP], 21'd0);
		// the fill adds no id 2047 and its insert above is refused as full, so the scan can cover every slot
		send_request(OP_DECREASE, 11'd2047, 21'd0);
		while (heap_fill > 0)
			send_request(OP_DELETE_MIN, 11'd0, '0);
		send_request(OP_DELETE_MIN, 11'd0, '0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		item_id = '0;
		key = '0;
		heap_fill = 0;
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stall_hold = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(125);
		test_backpressure();
		set_idling(59, 0);
		test_random_mix(125);
		set_idling(0, 59);
		test_random_mix(125);
		set_idling(31, 31);
		test_random_mix(125);
		set_idling(0, 0);
		test_fill_and_drain();

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ram.sv
rtl/core/min_heap_priority_queue_core.sv
test/min_heap_priority_queue_core_test.sv
